[design/spbm_pkg.sv]
// Shared types, constants and helper functions for the stereo peak bargraph meter.
// No dependencies; imported by every module of the block.
package spbm_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int BAR_LEVELS  = 10;
    localparam int PEAK_W      = SAMPLE_BITS - 1;
    localparam int BAR_W       = 16;
    localparam int CNT_W       = 16;
    localparam int LVL_W       = $clog2(BAR_LEVELS + 1);
    localparam int LHS_W       = PEAK_W + 8;
    localparam int SHIFT_W     = $clog2(BAR_W + 1);

    localparam logic [PEAK_W-1:0] MAXV      = {PEAK_W{1'b1}};
    localparam logic [CNT_W-1:0]  FPB_RESET = CNT_W'(4411);

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_FPB = 1'b0;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_passthrough;
        logic signed [SAMPLE_BITS-1:0] right_passthrough;
        logic                          bar_valid;
        logic [BAR_W-1:0]              left_bar;
        logic [BAR_W-1:0]              right_bar;
    } t_out_beat;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] left_sample;
        logic [SAMPLE_BITS-1:0] right_sample;
        logic                   last;
        logic [PEAK_W-1:0]      left_peak;
        logic [PEAK_W-1:0]      right_peak;
    } t_q_entry;

    function automatic logic [PEAK_W-1:0] magnitude(input logic [SAMPLE_BITS-1:0] s);
        logic [SAMPLE_BITS-1:0] a;
        a = s[SAMPLE_BITS-1] ? (~s + SAMPLE_BITS'(1)) : s;
        return a[SAMPLE_BITS-1] ? MAXV : a[PEAK_W-1:0];
    endfunction

    function automatic logic [LHS_W-1:0] level_thr(input int k);
        return LHS_W'(k * k) * LHS_W'(MAXV);
    endfunction

    function automatic logic [LVL_W-1:0] level_of(input logic [PEAK_W-1:0] peak);
        logic [LHS_W-1:0] lhs;
        logic [LVL_W-1:0] lvl;
        lhs = LHS_W'(peak) * LHS_W'(BAR_LEVELS * BAR_LEVELS);
        lvl = '0;
        for (int k = 1; k <= BAR_LEVELS; k++) begin
            if (lhs >= level_thr(k)) begin
                lvl = LVL_W'(k);
            end
        end
        return lvl;
    endfunction

    function automatic logic [BAR_W-1:0] bar_of(input logic [LVL_W-1:0] lvl);
        logic [BAR_W-1:0] ones;
        ones = '1;
        if (lvl == '0) begin
            return '0;
        end
        return ones << (SHIFT_W'(BAR_W) - SHIFT_W'(lvl));
    endfunction

endpackage

[design/spbm_front.sv]
// Front end: accepts frames, tracks per-channel peaks and the block frame count.
// Pushes one entry per frame into the queue. Depends on spbm_pkg.
module spbm_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  spbm_pkg::t_in_beat     i_in,
    input  logic [15:0]            i_fpb,
    output logic                   o_q_valid,
    input  logic                   i_q_ready,
    output spbm_pkg::t_q_entry     o_q_entry
);
    import spbm_pkg::*;

    logic [CNT_W-1:0]  r_count, n_count;
    logic [PEAK_W-1:0] r_lpeak, n_lpeak;
    logic [PEAK_W-1:0] r_rpeak, n_rpeak;
    logic [PEAK_W-1:0] lmag, rmag, lmax, rmax;
    logic [CNT_W:0]    cnt1;
    logic              last;
    logic              accept;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;

    always_comb begin
        lmag = magnitude(i_in.left_sample);
        rmag = magnitude(i_in.right_sample);
        lmax = (lmag > r_lpeak) ? lmag : r_lpeak;
        rmax = (rmag > r_rpeak) ? rmag : r_rpeak;
        cnt1 = {1'b0, r_count} + (CNT_W + 1)'(1);
        last = (cnt1 >= {1'b0, i_fpb});

        n_count = r_count;
        n_lpeak = r_lpeak;
        n_rpeak = r_rpeak;
        if (accept) begin
            n_count = last ? '0 : cnt1[CNT_W-1:0];
            n_lpeak = last ? '0 : lmax;
            n_rpeak = last ? '0 : rmax;
        end

        o_q_valid              = i_in_valid;
        o_q_entry.left_sample  = i_in.left_sample;
        o_q_entry.right_sample = i_in.right_sample;
        o_q_entry.last         = last;
        o_q_entry.left_peak    = lmax;
        o_q_entry.right_peak   = rmax;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_lpeak <= '0;
            r_rpeak <= '0;
        end else begin
            r_count <= n_count;
            r_lpeak <= n_lpeak;
            r_rpeak <= n_rpeak;
        end
    end

endmodule

[design/spbm_queue.sv]
// Two-entry queue between the front end and the bar stage.
// Depends on spbm_pkg.
module spbm_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push_valid,
    output logic                 o_push_ready,
    input  spbm_pkg::t_q_entry   i_push_entry,
    output logic                 o_pop_valid,
    input  logic                 i_pop_ready,
    output spbm_pkg::t_q_entry   o_pop_entry
);
    import spbm_pkg::*;

    t_q_entry         r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr, n_wr;
    logic [Q_AW-1:0]  r_rd, n_rd;
    logic [Q_CW-1:0]  r_cnt, n_cnt;
    logic             push, pop;

    assign o_push_ready = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_entry  = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_comb begin
        n_wr  = push ? r_wr + Q_AW'(1) : r_wr;
        n_rd  = pop  ? r_rd + Q_AW'(1) : r_rd;
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + Q_CW'(1);
        end else if (pop && !push) begin
            n_cnt = r_cnt - Q_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_entry;
        end
    end

endmodule

[design/spbm_back.sv]
// Back end: quantizes peaks to bar levels on block ends and holds the output beat.
// Depends on spbm_pkg.
module spbm_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  spbm_pkg::t_q_entry   i_q_entry,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output spbm_pkg::t_out_beat  o_out
);
    import spbm_pkg::*;

    t_out_beat r_out, n_out;
    logic      r_valid, n_valid;
    logic      take;

    assign o_q_ready   = !r_valid || i_out_ready;
    assign take        = i_q_valid && o_q_ready;
    assign o_out_valid = r_valid;
    assign o_out       = r_out;

    always_comb begin
        n_out.left_passthrough  = i_q_entry.left_sample;
        n_out.right_passthrough = i_q_entry.right_sample;
        n_out.bar_valid         = i_q_entry.last;
        n_out.left_bar          = i_q_entry.last ? bar_of(level_of(i_q_entry.left_peak)) : '0;
        n_out.right_bar         = i_q_entry.last ? bar_of(level_of(i_q_entry.right_peak)) : '0;
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= n_out;
        end
    end

endmodule

[design/stereo_peak_bargraph_meter.sv]
// Top level of the stereo peak bargraph meter: APB register, front end, queue, back end.
// Depends on spbm_pkg, spbm_front, spbm_queue, spbm_back.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in): one stereo frame per beat.
//   Output channel (o_out_valid/i_out_ready, o_out): exactly one beat per input
//   frame, carrying both samples unchanged; on the last frame of each block
//   bar_valid is set and left_bar/right_bar hold the peak level as leading ones.
//   APB port: register frames_per_block at byte address 0 (reset 4411, 0 acts as 1).
//   Path: an accepted frame is written into the queue, then registered in the
//   back end's output register, from which the receiver takes it.
//   Throughput: one frame per cycle while the receiver keeps up; the peak and
//   count update in the front end and the level compare in the back end are combinational.
//   The two-entry queue and the output register let the input keep flowing
//   while a result waits; when the receiver stalls, input is held off once
//   the queue fills.
//   Reset clears the peaks, the frame count, the queue and output valid, and
//   loads frames_per_block with its default; no clearing pass is needed.
module stereo_peak_bargraph_meter (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  spbm_pkg::t_in_beat                      i_in,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output spbm_pkg::t_out_beat                     o_out,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [spbm_pkg::PADDR_W-1:0]            paddr,
    input  logic [spbm_pkg::PDATA_W-1:0]            pwdata,
    output logic [spbm_pkg::PDATA_W-1:0]            prdata,
    output logic                                    pready
);
    import spbm_pkg::*;

    logic [CNT_W-1:0] r_fpb;
    logic             front_valid, front_ready;
    t_q_entry         front_entry;
    logic             back_valid, back_ready;
    t_q_entry         back_entry;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FPB) ? PDATA_W'(r_fpb) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fpb <= FPB_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_FPB)) begin
            r_fpb <= pwdata[CNT_W-1:0];
        end
    end

    spbm_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_fpb      (r_fpb),
        .o_q_valid  (front_valid),
        .i_q_ready  (front_ready),
        .o_q_entry  (front_entry)
    );

    spbm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_entry (front_entry),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_entry  (back_entry)
    );

    spbm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (back_valid),
        .o_q_ready   (back_ready),
        .i_q_entry   (back_entry),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

[design/spbm_checker.sv]
// Port-level checks for the stereo peak bargraph meter, bound to the top level.
// Depends on spbm_pkg.
module spbm_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  spbm_pkg::t_out_beat  o_out
);
    import spbm_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_bar_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.bar_valid) |-> (o_out.left_bar == '0 && o_out.right_bar == '0))
        else $error("bar pattern outside block end");

    a_bar_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (((~o_out.left_bar) & ((~o_out.left_bar) + BAR_W'(1))) == '0) &&
            (((~o_out.right_bar) & ((~o_out.right_bar) + BAR_W'(1))) == '0) &&
            ($countones(o_out.left_bar) <= BAR_LEVELS) &&
            ($countones(o_out.right_bar) <= BAR_LEVELS))
        else $error("bar pattern not leading ones");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("output beat changed while stalled");

endmodule

bind stereo_peak_bargraph_meter spbm_checker u_spbm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

[dv/stereo_peak_bargraph_meter_tb.sv]
// Self-checking testbench for stereo_peak_bargraph_meter: random and directed stereo frames,
// APB block-length writes, and a scoreboard that predicts every output beat.
// Depends on spbm_pkg and the design files under design/.
module stereo_peak_bargraph_meter_tb;
    import spbm_pkg::*;

    localparam int HALF_PERIOD = 4;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 38;
    localparam logic [PADDR_W-1:0] ADDR_FPB   = {REG_FPB, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_SPARE = PADDR_W'(4);

    class meter_scoreboard;
        logic [CNT_W-1:0]  blk_len;
        logic [CNT_W-1:0]  frames_seen;
        logic [PEAK_W-1:0] pk_l;
        logic [PEAK_W-1:0] pk_r;
        t_out_beat         pending[$];
        int                errors;
        int                n_in;
        int                n_out;
        int                n_bars;

        function new();
            blk_len     = FPB_RESET;
            frames_seen = '0;
            pk_l        = '0;
            pk_r        = '0;
            errors      = 0;
            n_in        = 0;
            n_out       = 0;
            n_bars      = 0;
        endfunction

        function logic [PEAK_W-1:0] clamp_mag(input logic [SAMPLE_BITS-1:0] s);
            logic [SAMPLE_BITS:0] m;
            m = s[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'(-$signed(s)) : {1'b0, s};
            if (m > (SAMPLE_BITS+1)'(MAXV)) m = (SAMPLE_BITS+1)'(MAXV);
            return m[PEAK_W-1:0];
        endfunction

        function logic [BAR_W-1:0] peak_bar(input logic [PEAK_W-1:0] pk);
            longint lhs;
            int     lvl;
            lhs = longint'(BAR_LEVELS) * BAR_LEVELS * pk;
            lvl = 0;
            for (int k = 1; k <= BAR_LEVELS; k++) begin
                if (lhs >= longint'(k) * k * MAXV) lvl = k;
            end
            if (lvl == 0) return '0;
            return 16'hffff << (BAR_W - lvl);
        endfunction

        function void reg_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] v);
            if (addr == ADDR_FPB) blk_len = v[CNT_W-1:0];
        endfunction

        function void note_input(input t_in_beat f);
            t_out_beat        e;
            logic [PEAK_W-1:0] ml;
            logic [PEAK_W-1:0] mr;
            ml = clamp_mag(f.left_sample);
            mr = clamp_mag(f.right_sample);
            if (ml > pk_l) pk_l = ml;
            if (mr > pk_r) pk_r = mr;
            e.left_passthrough  = f.left_sample;
            e.right_passthrough = f.right_sample;
            if ({1'b0, frames_seen} + 17'd1 >= {1'b0, blk_len}) begin
                e.bar_valid = 1'b1;
                e.left_bar  = peak_bar(pk_l);
                e.right_bar = peak_bar(pk_r);
                pk_l        = '0;
                pk_r        = '0;
                frames_seen = '0;
            end else begin
                e.bar_valid = 1'b0;
                e.left_bar  = '0;
                e.right_bar = '0;
                frames_seen = frames_seen + 1'b1;
            end
            pending.push_back(e);
            n_in++;
        endfunction

        function void check_result(input t_out_beat got);
            t_out_beat e;
            n_out++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected output beat %h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.bar_valid) n_bars++;
            if (got.left_passthrough !== e.left_passthrough) begin
                $display("%0t: left_passthrough exp %h got %h", $time,
                         e.left_passthrough, got.left_passthrough);
                errors++;
            end
            if (got.right_passthrough !== e.right_passthrough) begin
                $display("%0t: right_passthrough exp %h got %h", $time,
                         e.right_passthrough, got.right_passthrough);
                errors++;
            end
            if (got.bar_valid !== e.bar_valid) begin
                $display("%0t: bar_valid exp %b got %b", $time, e.bar_valid, got.bar_valid);
                errors++;
            end
            if (got.left_bar !== e.left_bar) begin
                $display("%0t: left_bar exp %h got %h", $time, e.left_bar, got.left_bar);
                errors++;
            end
            if (got.right_bar !== e.right_bar) begin
                $display("%0t: right_bar exp %h got %h", $time, e.right_bar, got.right_bar);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                in_valid    = 1'b0;
    logic                o_in_ready;
    t_in_beat            in_beat     = '0;
    logic                o_out_valid;
    logic                out_ready   = 1'b0;
    t_out_beat           o_out;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    meter_scoreboard sb = new();
    bit              no_idle = 1'b0;
    int              cycles  = 0;
    int              n_writes = 0;

    stereo_peak_bargraph_meter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_beat),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        if (i_rst_n && o_out_valid && out_ready) sb.check_result(o_out);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("stereo_peak_bargraph_meter test failed");
            $finish;
        end
    end

    task automatic send_frame(input logic [SAMPLE_BITS-1:0] l, input logic [SAMPLE_BITS-1:0] r);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= '{left_sample: l, right_sample: r};
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input('{left_sample: l, right_sample: r});
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [CNT_W-1:0] v);
        logic [PDATA_W-1:0] word;
        word    = {16'($urandom_range(65535)), v};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.reg_write(addr, word);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_writes++;
    endtask

    function automatic logic [SAMPLE_BITS-1:0] rand_sample(input int cap);
        int m;
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: begin
                m = $urandom_range(BAR_LEVELS, 1);
                m = (m * m * MAXV + 99) / 100 - int'($urandom_range(1));
                return $urandom_range(1) ? 16'(m) : 16'(-m);
            end
            3, 4, 5: begin
                m = $urandom_range(cap);
                return $urandom_range(1) ? 16'(m) : 16'(-m);
            end
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int n_items);
        int cap;
        int pause_at;
        cap      = 1 << $urandom_range(15, 1);
        pause_at = $urandom_range(n_items - 1);
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0) cap = (1 << $urandom_range(15, 1)) - 1;
            if (i == pause_at) begin
                in_valid <= 1'b0;
                drain();
            end
            send_frame(rand_sample(cap), rand_sample(cap));
        end
        in_valid <= 1'b0;
        drain();
    endtask

    initial begin
        logic [CNT_W-1:0] lens[10];
        int               thr;
        lens = '{16'd1, 16'd2, 16'd3, 16'd5, 16'd16, 16'd37, 16'd0, 16'hffff, 16'd200, 16'd1};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // default block length, mid-block when the first write lands
        random_phase(150);

        apb_write(ADDR_FPB, 16'd1);
        send_frame(16'h0000, 16'h0000);
        send_frame(16'h7fff, 16'h8000);
        send_frame(16'h8000, 16'h7fff);
        send_frame(16'h8001, 16'h0001);
        send_frame(16'hffff, 16'h0000);
        send_frame(16'd32766, -16'sd32766);
        send_frame(16'h8000, 16'h8000);
        send_frame(16'h5555, 16'haaaa);
        for (int k = 1; k <= BAR_LEVELS; k++) begin
            thr = (k * k * MAXV + 99) / 100;
            send_frame(16'(thr), 16'(-(thr - 1)));
        end
        in_valid <= 1'b0;
        drain();

        apb_write(ADDR_FPB, 16'd0);
        send_frame(16'h1234, 16'hedcb);
        send_frame(16'h7ffe, 16'h0002);
        in_valid <= 1'b0;
        drain();

        // shorten the block once five frames are already counted
        apb_write(ADDR_FPB, 16'd8);
        for (int i = 0; i < 5; i++) send_frame(16'(i * 3000), 16'(-i * 5000));
        in_valid <= 1'b0;
        drain();
        apb_write(ADDR_FPB, 16'd3);
        apb_write(ADDR_SPARE, 16'd9);
        send_frame(16'h0100, 16'hff00);
        send_frame(16'h0001, 16'h0001);
        in_valid <= 1'b0;
        drain();

        foreach (lens[p]) begin
            apb_write(ADDR_FPB, lens[p]);
            no_idle = (p == 4);
            random_phase(160);
        end
        no_idle = 1'b0;
        drain();

        $display("Frames sent: %0d, output beats checked: %0d, bar updates: %0d, APB writes: %0d",
                 sb.n_in, sb.n_out, sb.n_bars, n_writes);
        $display("Block lengths from 0 to 65535, both sides stalling at random, %0d errors",
                 sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("stereo_peak_bargraph_meter test passed");
        end else begin
            $display("stereo_peak_bargraph_meter test failed");
        end
        $finish;
    end
endmodule

[sim.f]
design/spbm_pkg.sv
design/spbm_front.sv
design/spbm_queue.sv
design/spbm_back.sv
design/stereo_peak_bargraph_meter.sv
design/spbm_checker.sv
dv/stereo_peak_bargraph_meter_tb.sv
